/* hdl/mgt_pkg.sv */
// Package for the multitouch gesture tracker.
// Holds opcodes, result codes, register indexes and the packed item widths.
// No dependencies.
package mgt_pkg;

  localparam int ID_W    = 8;
  localparam int COORD_W = 16;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 2;
  localparam int EV_W    = 2;
  localparam int CNT_W   = 5;
  localparam int OP_W    = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  localparam logic [OP_W-1:0] OP_BEGIN  = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
  localparam logic [OP_W-1:0] OP_END    = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_HANDLED   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNHANDLED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_BEGAN   = 2'd1;
  localparam logic [EV_W-1:0] EV_UPDATED = 2'd2;
  localparam logic [EV_W-1:0] EV_ENDED   = 2'd3;

  localparam logic REG_ACTIVE_LO = 1'b0;
  localparam logic REG_ACTIVE_HI = 1'b1;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -16'sh8000;

endpackage

/* hdl/mgt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mgt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/multitouch_gesture_tracker.sv */
// Top level of the multitouch gesture tracker.
// Depends on mgt_pkg and mgt_ram.
//
// The block keeps a table of up to MAX_SLOTS touch points and answers every input item with
// exactly one result item. It takes one item at a time and accepts no new item until it is
// done with the last: a pass over the slot RAM looks up the touch id and a free slot, the
// change is applied, a second pass over the slot RAM builds the bounding box, the output
// register is loaded and the block returns to idle to take the next item, all through the
// single read port of the slot RAM. The output register lets the next item be taken while an
// earlier result still waits to be read; if that result is still waiting when the next one is
// ready, the block holds until it is read. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the block itself does
// not enforce.
module multitouch_gesture_tracker #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mgt_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // touch_id[7:0], touch_x[23:8], touch_y[39:24]
  input  logic [mgt_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode[2:0]
  input  logic [mgt_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[1:0], gesture_event[3:2], touch_count[8:4], center_valid[9], mid_x[25:10],
  // mid_y[41:26], found[42], found_x[58:43], found_y[74:59], zero[79:75]
  output logic [mgt_pkg::OUT_DATA_W-1:0]    m_tdata
);

  import mgt_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int RW = (CW > CFG_W) ? CW : CFG_W;
  localparam int MW = ID_W + 2 * COORD_W;
  localparam logic [CW-1:0] LAST = CW'(MAX_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN1 = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_SCAN2 = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                 state;
  logic [CW-1:0]              scan_cnt;
  logic                       pipe_vld;
  logic [AW-1:0]              pipe_idx;
  logic [AW-1:0]              rd_addr;
  logic [MW-1:0]              rd_data;
  logic [ID_W-1:0]            rd_id;
  logic signed [COORD_W-1:0]  rd_x;
  logic signed [COORD_W-1:0]  rd_y;

  logic [CFG_W-1:0]           active_lo;
  logic [CFG_W-1:0]           active_hi;
  logic [MAX_SLOTS-1:0]       slot_valid;
  logic [CW-1:0]              active_count;

  logic [OP_W-1:0]            op;
  logic [ID_W-1:0]            id;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;

  logic                       hit;
  logic [AW-1:0]              hit_idx;
  logic signed [COORD_W-1:0]  hit_x;
  logic signed [COORD_W-1:0]  hit_y;
  logic                       has_free;
  logic [AW-1:0]              free_idx;

  logic signed [COORD_W-1:0]  xmin;
  logic signed [COORD_W-1:0]  xmax;
  logic signed [COORD_W-1:0]  ymin;
  logic signed [COORD_W-1:0]  ymax;
  logic                       any;

  logic [STAT_W-1:0]          status;
  logic [EV_W-1:0]            gev;
  logic                       found;
  logic signed [COORD_W-1:0]  found_x;
  logic signed [COORD_W-1:0]  found_y;

  logic [STAT_W-1:0]          status_next;
  logic [EV_W-1:0]            gev_next;
  logic                       found_next;
  logic [CW-1:0]              count_next;
  logic [MAX_SLOTS-1:0]       valid_next;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       was;
  logic                       is_now;
  logic                       rule;

  logic                       cv;
  logic [COORD_W:0]           dx;
  logic [COORD_W:0]           dy;
  logic signed [COORD_W-1:0]  cx;
  logic signed [COORD_W-1:0]  cy;

  function automatic logic in_rng(input logic [CW-1:0] n, input logic [CFG_W-1:0] lo,
                                  input logic [CFG_W-1:0] hi);
    logic [RW-1:0] nw;
    nw = RW'(n);
    return (nw >= RW'(lo)) && (nw <= RW'(hi));
  endfunction

  assign rd_addr = (scan_cnt != LAST) ? scan_cnt[AW-1:0] : '0;
  assign rd_id   = rd_data[MW-1 -: ID_W];
  assign rd_y    = rd_data[2*COORD_W-1 -: COORD_W];
  assign rd_x    = rd_data[COORD_W-1:0];

  mgt_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({id, py, px}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    status_next = STAT_HANDLED;
    gev_next    = EV_NONE;
    found_next  = 1'b0;
    count_next  = active_count;
    valid_next  = slot_valid;
    wr_en       = 1'b0;
    wr_addr     = hit_idx;
    rule        = 1'b0;
    was         = in_rng(active_count, active_lo, active_hi);
    if (op == OP_RESET) begin
      gev_next   = was ? EV_ENDED : EV_NONE;
      valid_next = '0;
      count_next = '0;
    end else if (op == OP_QUERY) begin
      found_next = hit && (id != '0);
    end else if ((id == '0) || (op > OP_QUERY)) begin
      status_next = STAT_UNHANDLED;
    end else begin
      rule = 1'b1;
      case (op)
        OP_BEGIN: begin
          if (hit) begin
            wr_en = state == ST_APPLY;
          end else if (has_free) begin
            wr_en                = state == ST_APPLY;
            wr_addr              = free_idx;
            valid_next[free_idx] = 1'b1;
            count_next           = active_count + CW'(1);
          end else begin
            status_next = STAT_FULL;
            rule        = 1'b0;
          end
        end
        OP_UPDATE: begin
          if (hit) begin
            wr_en = state == ST_APPLY;
          end else begin
            status_next = STAT_UNHANDLED;
            rule        = 1'b0;
          end
        end
        default: begin
          if (hit) begin
            valid_next[hit_idx] = 1'b0;
            count_next          = active_count - CW'(1);
          end
        end
      endcase
    end
    is_now = in_rng(count_next, active_lo, active_hi);
    if (rule) begin
      if (is_now) begin
        gev_next = was ? EV_UPDATED : EV_BEGAN;
      end else if (was) begin
        gev_next = EV_ENDED;
      end
    end
  end

  always_comb begin
    cv = in_rng(active_count, active_lo, active_hi);
    dx = {xmax[COORD_W-1], xmax} - {xmin[COORD_W-1], xmin};
    dy = {ymax[COORD_W-1], ymax} - {ymin[COORD_W-1], ymin};
    cx = xmin + $signed(dx[COORD_W:1]);
    cy = ymin + $signed(dy[COORD_W:1]);
    if (!(cv && any)) begin
      cx = '0;
      cy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_cnt     <= '0;
      pipe_vld     <= 1'b0;
      active_lo    <= CFG_W'(1);
      active_hi    <= CFG_W'(1);
      slot_valid   <= '0;
      active_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE_LO) begin
          active_lo <= cfg_data;
        end else begin
          active_hi <= cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      pipe_vld <= ((state == ST_SCAN1) || (state == ST_SCAN2)) && (scan_cnt != LAST);
      pipe_idx <= rd_addr;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op       <= s_tuser;
            id       <= s_tdata[ID_W-1:0];
            px       <= s_tdata[ID_W+COORD_W-1 -: COORD_W];
            py       <= s_tdata[ID_W+2*COORD_W-1 -: COORD_W];
            scan_cnt <= '0;
            hit      <= 1'b0;
            has_free <= 1'b0;
            state    <= ST_SCAN1;
          end
        end
        ST_SCAN1: begin
          if (pipe_vld) begin
            if (slot_valid[pipe_idx] && (rd_id == id) && !hit) begin
              hit     <= 1'b1;
              hit_idx <= pipe_idx;
              hit_x   <= rd_x;
              hit_y   <= rd_y;
            end
            if (!slot_valid[pipe_idx] && !has_free) begin
              has_free <= 1'b1;
              free_idx <= pipe_idx;
            end
          end
          if (scan_cnt == LAST) begin
            state <= ST_APPLY;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        ST_APPLY: begin
          slot_valid   <= valid_next;
          active_count <= count_next;
          status       <= status_next;
          gev          <= gev_next;
          found        <= found_next;
          found_x      <= found_next ? hit_x : '0;
          found_y      <= found_next ? hit_y : '0;
          xmin         <= COORD_MAX;
          ymin         <= COORD_MAX;
          xmax         <= COORD_MIN;
          ymax         <= COORD_MIN;
          any          <= 1'b0;
          scan_cnt     <= '0;
          state        <= ST_SCAN2;
        end
        ST_SCAN2: begin
          if (pipe_vld && slot_valid[pipe_idx]) begin
            any <= 1'b1;
            if (rd_x < xmin) xmin <= rd_x;
            if (rd_x > xmax) xmax <= rd_x;
            if (rd_y < ymin) ymin <= rd_y;
            if (rd_y > ymax) ymax <= rd_y;
          end
          if (scan_cnt == LAST) begin
            state <= ST_DONE;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, found_y, found_x, found, cy, cx, cv,
                  CNT_W'(active_count), gev, status};
    end
  end

endmodule

/* hdl/mgt_checker.sv */
// Port-level checker for the multitouch gesture tracker and its bind statement.
// Depends on mgt_pkg and the top level's port list.
module mgt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  import mgt_pkg::*;

  // The block works on one item at a time, so it is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // Only a handled item can report a gesture event.
  a_event_needs_handled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != STAT_HANDLED) |-> m_tdata[3:2] == EV_NONE)
    else $error("gesture event on an item that was not handled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] <= STAT_FULL)
    else $error("status code out of range");

  // Without an in-range count the center is reported as zero.
  a_center_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] |-> m_tdata[41:10] == 32'd0)
    else $error("center reported while the count is out of range");

endmodule

bind multitouch_gesture_tracker mgt_checker u_mgt_checker (.*);
